// ===== src/hbmc_pkg.sv =====
package hbmc_pkg;

  localparam int unsigned LEVEL_W          = 3;
  localparam int unsigned LEVEL_SLOTS      = 6;
  localparam int unsigned LEVEL_COUNT_DEF  = 6;
  localparam int unsigned DRIVE_W          = 8;
  localparam int unsigned TIME_W           = 16;
  localparam int unsigned IDLE_W           = 8;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned CFG_INDEX_W      = 3;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [STATUS_W-1:0] ST_RELEASED      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESSED       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_JUST_RELEASED = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LIMIT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL0         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL1         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL2         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL3         = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL4         = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL5         = 3'd7;

  localparam logic [TIME_W-1:0] HOLD_THRESHOLD_RST = 16'd100;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST     = 8'd200;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [LEVEL_SLOTS-1:0][DRIVE_W-1:0] level_table_t;

  localparam level_table_t LEVEL_TABLE_RST = {8'd200, 8'd150, 8'd100, 8'd40, 8'd5, 8'd0};

  typedef struct packed {
    logic [STATUS_W-1:0] up_status;
    logic [TIME_W-1:0]   up_press_time;
    logic [STATUS_W-1:0] down_status;
    logic [TIME_W-1:0]   down_press_time;
  } buttons_t;

  typedef struct packed {
    level_t            spot_level;
    level_t            flood_level;
    logic              red_level;
    level_t            saved_spot;
    level_t            saved_flood;
    logic              saved_red;
    logic              hold_consumed;
    logic              asleep;
    logic [IDLE_W-1:0] idle_ticks;
  } lamp_state_t;

  typedef struct packed {
    level_t flood_level;
    level_t spot_level;
    logic   red_on;
    logic   power_down;
  } lamp_result_t;

  localparam lamp_state_t LAMP_STATE_RST = '{
    spot_level:    '0,
    flood_level:   '0,
    red_level:     1'b0,
    saved_spot:    '0,
    saved_flood:   '0,
    saved_red:     1'b0,
    hold_consumed: 1'b0,
    asleep:        1'b1,
    idle_ticks:    '0
  };

  function automatic logic [DRIVE_W-1:0] drive_of(level_t lvl, level_table_t tbl);
    logic [DRIVE_W-1:0] d;
    d = '0;
    if (32'(lvl) < LEVEL_SLOTS) begin
      d = tbl[lvl];
    end
    return d;
  endfunction

endpackage

// ===== src/hbmc_rules.sv =====
module hbmc_rules #(
  parameter int unsigned LEVEL_COUNT = hbmc_pkg::LEVEL_COUNT_DEF
) (
  input  hbmc_pkg::buttons_t               btn_i,
  input  hbmc_pkg::lamp_state_t            state_i,
  input  logic [hbmc_pkg::TIME_W-1:0]      hold_threshold_i,
  input  logic [hbmc_pkg::IDLE_W-1:0]      idle_limit_i,
  output hbmc_pkg::lamp_state_t            state_o,
  output hbmc_pkg::lamp_result_t           result_o
);
  import hbmc_pkg::*;

  localparam level_t LastLevel = LEVEL_W'(LEVEL_COUNT - 1);

  lamp_state_t       st;
  logic              long_dn;
  logic              long_up;
  logic              short_up;
  logic              short_dn;
  logic [IDLE_W-1:0] ticks_inc;

  always_comb begin
    st        = state_i;
    long_up   = 1'b0;
    ticks_inc = '0;
    result_o  = '0;

    long_dn = (btn_i.down_status == ST_PRESSED) &&
              (btn_i.down_press_time >= hold_threshold_i) && !st.hold_consumed;
    if (long_dn) begin
      st.hold_consumed = 1'b1;
      st.red_level     = ~st.red_level;
      if (st.red_level) begin
        st.asleep = 1'b0;
      end
    end

    long_up = (btn_i.up_status == ST_PRESSED) &&
              (btn_i.up_press_time >= hold_threshold_i) && !st.hold_consumed;
    if (long_up) begin
      st.hold_consumed = 1'b1;
      if (st.asleep) begin
        st.asleep      = 1'b0;
        st.spot_level  = st.saved_spot;
        st.flood_level = st.saved_flood;
        st.red_level   = st.saved_red;
        if (!st.red_level && st.spot_level == '0 && st.flood_level == '0) begin
          st.flood_level = LEVEL_W'(1);
        end
      end else begin
        st.asleep      = 1'b1;
        st.saved_spot  = st.spot_level;
        st.saved_flood = st.flood_level;
        st.saved_red   = st.red_level;
        st.spot_level  = '0;
        st.flood_level = '0;
        st.red_level   = 1'b0;
      end
    end

    short_up = (btn_i.up_status == ST_JUST_RELEASED) &&
               (btn_i.up_press_time <= hold_threshold_i);
    short_dn = (btn_i.down_status == ST_JUST_RELEASED) &&
               (btn_i.down_press_time <= hold_threshold_i);
    if (!st.asleep) begin
      if (short_up) begin
        st.spot_level = (st.spot_level >= LastLevel) ? '0 : st.spot_level + LEVEL_W'(1);
      end
      if (short_dn) begin
        st.flood_level = (st.flood_level >= LastLevel) ? '0 : st.flood_level + LEVEL_W'(1);
      end
    end

    result_o.flood_level = st.flood_level;
    result_o.spot_level  = st.spot_level;
    result_o.red_on      = st.red_level;

    if (btn_i.up_status == ST_RELEASED && btn_i.down_status == ST_RELEASED) begin
      st.hold_consumed = 1'b0;
      if (st.flood_level == '0 && st.spot_level == '0 && !st.red_level) begin
        ticks_inc     = st.idle_ticks + IDLE_W'(1);
        st.idle_ticks = ticks_inc;
        if (ticks_inc > idle_limit_i) begin
          if (!st.asleep) begin
            st.asleep      = 1'b1;
            st.saved_spot  = st.spot_level;
            st.saved_flood = st.flood_level;
            st.saved_red   = st.red_level;
          end
          result_o.power_down = 1'b1;
          st.idle_ticks       = '0;
        end
      end
    end else begin
      st.idle_ticks = '0;
    end

    state_o = st;
  end

endmodule

// ===== src/headlamp_button_mode_control_unit.sv =====
// Headlamp button mode control.
// Input channel (in_valid/in_ready): one transfer per 10 ms tick carrying the
// status and press time of the up and down buttons.
// Output channel (out_valid/out_ready): one transfer per input tick with the
// flood and spot drive values, the red LED level and a power-down pulse.
// Configuration (cfg_we/cfg_index/cfg_wdata): hold threshold, idle limit and
// the six level drive values; write only while no tick is in flight.
// Pipeline: a tick passes through the input register, then the result
// register. Throughput: one tick per cycle unless out_ready stalls the
// output; the lamp state is updated by combinational logic between the
// input register and the result register.
// Reset: the lamp starts asleep with all levels at 0, the idle count cleared
// and the configuration at its default values; both pipeline stages empty.
// Stall: with out_ready low the result holds, the input register fills and
// in_ready drops once both stages are occupied.
module headlamp_button_mode_control_unit #(
  parameter int unsigned LEVEL_COUNT = hbmc_pkg::LEVEL_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hbmc_pkg::STATUS_W-1:0]       in_up_status,
  input  logic [hbmc_pkg::TIME_W-1:0]         in_up_press_time,
  input  logic [hbmc_pkg::STATUS_W-1:0]       in_down_status,
  input  logic [hbmc_pkg::TIME_W-1:0]         in_down_press_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hbmc_pkg::DRIVE_W-1:0]        out_flood_drive,
  output logic [hbmc_pkg::DRIVE_W-1:0]        out_spot_drive,
  output logic                                out_red_on,
  output logic                                out_power_down,
  input  logic                                cfg_we,
  input  logic [hbmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hbmc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hbmc_pkg::*;

  logic [TIME_W-1:0]  hold_threshold_r, hold_threshold_nxt;
  logic [IDLE_W-1:0]  idle_limit_r, idle_limit_nxt;
  level_table_t       level_drive_r, level_drive_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  buttons_t           s1_btn_r, s1_btn_nxt;
  logic               s1_adv;

  lamp_state_t        state_r, state_nxt;
  lamp_state_t        rules_state;
  lamp_result_t       rules_result;

  logic               out_valid_r, out_valid_nxt;
  logic [DRIVE_W-1:0] flood_drive_r, flood_drive_nxt;
  logic [DRIVE_W-1:0] spot_drive_r, spot_drive_nxt;
  logic               red_on_r, red_on_nxt;
  logic               power_down_r, power_down_nxt;

  // configuration registers
  always_comb begin
    hold_threshold_nxt = hold_threshold_r;
    idle_limit_nxt     = idle_limit_r;
    level_drive_nxt    = level_drive_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD_THRESHOLD: hold_threshold_nxt = cfg_wdata;
        CFG_IDLE_LIMIT:     idle_limit_nxt     = cfg_wdata[IDLE_W-1:0];
        CFG_LEVEL0:         level_drive_nxt[0] = cfg_wdata[DRIVE_W-1:0];
        CFG_LEVEL1:         level_drive_nxt[1] = cfg_wdata[DRIVE_W-1:0];
        CFG_LEVEL2:         level_drive_nxt[2] = cfg_wdata[DRIVE_W-1:0];
        CFG_LEVEL3:         level_drive_nxt[3] = cfg_wdata[DRIVE_W-1:0];
        CFG_LEVEL4:         level_drive_nxt[4] = cfg_wdata[DRIVE_W-1:0];
        CFG_LEVEL5:         level_drive_nxt[5] = cfg_wdata[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_btn_nxt   = s1_btn_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
      s1_btn_nxt   = '{
        up_status:       in_up_status,
        up_press_time:   in_up_press_time,
        down_status:     in_down_status,
        down_press_time: in_down_press_time
      };
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  hbmc_rules #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_rules (
    .btn_i            (s1_btn_r),
    .state_i          (state_r),
    .hold_threshold_i (hold_threshold_r),
    .idle_limit_i     (idle_limit_r),
    .state_o          (rules_state),
    .result_o         (rules_result)
  );

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    flood_drive_nxt = flood_drive_r;
    spot_drive_nxt  = spot_drive_r;
    red_on_nxt      = red_on_r;
    power_down_nxt  = power_down_r;
    if (s1_adv) begin
      state_nxt       = rules_state;
      out_valid_nxt   = 1'b1;
      flood_drive_nxt = drive_of(rules_result.flood_level, level_drive_r);
      spot_drive_nxt  = drive_of(rules_result.spot_level, level_drive_r);
      red_on_nxt      = rules_result.red_on;
      power_down_nxt  = rules_result.power_down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_threshold_r <= HOLD_THRESHOLD_RST;
      idle_limit_r     <= IDLE_LIMIT_RST;
      level_drive_r    <= LEVEL_TABLE_RST;
      s1_valid_r       <= 1'b0;
      state_r          <= LAMP_STATE_RST;
      out_valid_r      <= 1'b0;
    end else begin
      hold_threshold_r <= hold_threshold_nxt;
      idle_limit_r     <= idle_limit_nxt;
      level_drive_r    <= level_drive_nxt;
      s1_valid_r       <= s1_valid_nxt;
      state_r          <= state_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_btn_r      <= s1_btn_nxt;
    flood_drive_r <= flood_drive_nxt;
    spot_drive_r  <= spot_drive_nxt;
    red_on_r      <= red_on_nxt;
    power_down_r  <= power_down_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_flood_drive = flood_drive_r;
  assign out_spot_drive  = spot_drive_r;
  assign out_red_on      = red_on_r;
  assign out_power_down  = power_down_r;

`ifndef NO_ASSERTIONS
  a_pwr_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && power_down_r |-> !red_on_r)
    else $error("power-down with red LED lit");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(state_r.spot_level) < LEVEL_COUNT) && (32'(state_r.flood_level) < LEVEL_COUNT))
    else $error("lamp level out of range");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !s1_adv |=> $stable(state_r))
    else $error("lamp state changed without a tick");

  a_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("pending tick dropped");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && s1_adv |=> out_valid_r)
    else $error("result not loaded after tick");
`endif

endmodule
